@@ rtl/ndh_pkg.sv @@
package ndh_pkg;

  // Histogram geometry
  localparam int NUM_BINS = 2000;
  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(NUM_BINS - 1);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int SEQ_W   = 16;
  localparam int LOCUS_W = 31;
  localparam int IDX_W   = 11;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 48;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;     // capture the accepted item
    logic look;         // evaluate sample / issue bin read
    logic bump;         // bin read data is back: update or capture
    logic sweep_start;  // zero totals and restart the clear sweep
    logic sweep_step;   // write zero at the sweep address and advance
    logic load_out;     // move the result into the output register
  } ndh_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              binned;
    logic              sweep_last;
  } ndh_sts_t;

endpackage

@@ rtl/ndh_ram.sv @@
module ndh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ndh_ctrl.sv @@
module ndh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ndh_pkg::ndh_sts_t sts,
  output ndh_pkg::ndh_cmd_t cmd
);

  import ndh_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_LOOK = 3'd2;
  localparam logic [2:0] ST_BUMP = 3'd3;
  localparam logic [2:0] ST_WIPE = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        priority if (sts.kind == KIND_CLEAR) begin
          cmd.sweep_start = 1'b1;
          state_next      = ST_WIPE;
        end else if (sts.kind == KIND_READ) begin
          cmd.look   = 1'b1;
          state_next = ST_BUMP;
        end else if (sts.kind == KIND_SAMPLE) begin
          cmd.look   = 1'b1;
          state_next = sts.binned ? ST_BUMP : ST_EMIT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_BUMP: begin
        cmd.bump   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_WIPE: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/ndh_datapath.sv @@
module ndh_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ndh_pkg::ndh_cmd_t               cmd,
  output ndh_pkg::ndh_sts_t               sts,
  input  logic [ndh_pkg::KIND_W-1:0]      in_kind,
  input  logic [ndh_pkg::SEQ_W-1:0]       in_seq_id,
  input  logic [ndh_pkg::LOCUS_W-1:0]     in_locus,
  input  logic [ndh_pkg::IDX_W-1:0]       in_bin_index,
  output logic [ndh_pkg::LOCUS_W-1:0]     distance,
  output logic                            chain_start,
  output logic                            order_error,
  output logic [ndh_pkg::COUNT_W-1:0]     bin_value,
  output logic [ndh_pkg::COUNT_W-1:0]     pair_total,
  output logic [ndh_pkg::SUM_W-1:0]       distance_total
);

  import ndh_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [31:0]        NUM_BINS_W = 32'(NUM_BINS);
  localparam logic [LOCUS_W-1:0] TOP_DIST   = LOCUS_W'(NUM_BINS - 1);

  // Accepted item
  logic [KIND_W-1:0]  kind_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [LOCUS_W-1:0] loc_r;
  logic [IDX_W-1:0]   idx_r;

  // Chain state
  logic               have_prev;
  logic [SEQ_W-1:0]   prev_seq;
  logic [LOCUS_W-1:0] prev_loc;

  // Totals and sweep
  logic [COUNT_W-1:0] pair_count;
  logic [SUM_W-1:0]   dist_sum;
  logic [BIN_AW-1:0]  sweep_addr;

  // Per-item results
  logic [LOCUS_W-1:0] res_dist;
  logic               res_start;
  logic               res_err;
  logic [COUNT_W-1:0] res_bin;
  logic [BIN_AW-1:0]  slot_r;
  logic               in_range_r;

  logic               is_sample;
  logic               new_chain;
  logic               backward;
  logic [LOCUS_W-1:0] diff;
  logic               binned;
  logic [BIN_AW-1:0]  slot;
  logic               in_range;
  logic [SUM_W:0]     sum_ext;

  logic               ram_we;
  logic [BIN_AW-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [BIN_AW-1:0]  ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  assign is_sample = (kind_r == KIND_SAMPLE);
  assign new_chain = !have_prev || (seq_r != prev_seq);
  assign backward  = (loc_r < prev_loc);
  assign diff      = loc_r - prev_loc;
  assign binned    = is_sample && !new_chain && !backward;
  assign slot      = (diff >= TOP_DIST) ? LAST_BIN : diff[BIN_AW-1:0];
  assign in_range  = ({{(32 - IDX_W){1'b0}}, idx_r} < NUM_BINS_W);
  assign sum_ext   = {1'b0, dist_sum} + {{(SUM_W + 1 - LOCUS_W){1'b0}}, res_dist};

  assign sts.kind       = kind_r;
  assign sts.binned     = binned;
  assign sts.sweep_last = (sweep_addr == LAST_BIN);

  // One write port shared by the clear sweep and the bin update
  assign ram_we    = cmd.sweep_step || (cmd.bump && is_sample);
  assign ram_waddr = cmd.sweep_step ? sweep_addr : slot_r;
  assign ram_wdata = cmd.sweep_step ? '0 :
                     ((ram_rdata == COUNT_MAX) ? COUNT_MAX : ram_rdata + 1'b1);
  assign ram_raddr = is_sample ? slot : BIN_AW'(idx_r);

  ndh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.look),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_seq   <= '0;
      prev_loc   <= '0;
      pair_count <= '0;
      dist_sum   <= '0;
      sweep_addr <= '0;
    end else begin
      if (cmd.look && is_sample) begin
        if (new_chain) begin
          have_prev <= 1'b1;
          prev_seq  <= seq_r;
          prev_loc  <= loc_r;
        end else if (!backward) begin
          prev_loc <= loc_r;
        end
      end
      if (cmd.sweep_start) begin
        pair_count <= '0;
        dist_sum   <= '0;
        sweep_addr <= '0;
      end else if (cmd.sweep_step) begin
        sweep_addr <= sts.sweep_last ? '0 : sweep_addr + 1'b1;
      end else if (cmd.bump && is_sample) begin
        if (pair_count != COUNT_MAX) begin
          pair_count <= pair_count + 1'b1;
        end
        dist_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r    <= in_kind;
      seq_r     <= in_seq_id;
      loc_r     <= in_locus;
      idx_r     <= in_bin_index;
      res_dist  <= '0;
      res_start <= 1'b0;
      res_err   <= 1'b0;
      res_bin   <= '0;
    end
    if (cmd.look) begin
      slot_r     <= slot;
      in_range_r <= in_range;
      if (is_sample) begin
        res_start <= new_chain;
        res_err   <= !new_chain && backward;
        res_dist  <= binned ? diff : '0;
      end
    end
    if (cmd.bump && !is_sample) begin
      res_bin <= in_range_r ? ram_rdata : '0;
    end
    if (cmd.load_out) begin
      distance       <= res_dist;
      chain_start    <= res_start;
      order_error    <= res_err;
      bin_value      <= res_bin;
      pair_total     <= pair_count;
      distance_total <= dist_sum;
    end
  end

endmodule

@@ rtl/neighbour_distance_histogram_unit.sv @@
// Neighbour distance histogram. Feed position samples sorted by sequence id and
// ascending locus; each sample on the same sequence as the last kept sample
// bins its distance (top bin catches NUM_BINS-1 and beyond) and adds to the
// saturating pair count and distance sum. A new sequence id only restarts the
// chain; a locus that goes backwards is flagged as an order error and dropped.
// Read items return one bin (zero beyond the last bin), clear items zero the
// histogram and totals but keep the chain. Every item yields exactly one result
// transaction. Timing: a controller sequences one item at a time through the
// single-port-per-direction bin memory, whose read is registered. A sample
// that is binned or a read item passes through the look, bump and emit states
// before the next acceptance; a sample that is not binned or an unused kind
// goes from look straight to emit. A clear runs the sweep, which zeroes one
// bin per cycle, between look and emit. A result that is still waiting on the
// receiver holds the item in its last cycle until the earlier result is taken.
// After reset the same sweep zeroes every bin before the first item is taken.
// The output register lets the next item be accepted while a result waits.
module neighbour_distance_histogram_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // seq_id[15:0], locus[46:16], bin_index[57:47]
  input  logic [1:0]    s_axis_tuser,   // kind[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // distance[30:0], bin_value[62:31],
                                        // pair_total[94:63], distance_total[142:95]
  output logic [1:0]    m_axis_tuser    // chain_start[0], order_error[1]
);

  import ndh_pkg::*;

  ndh_cmd_t           cmd;
  ndh_sts_t           sts;
  logic [LOCUS_W-1:0] distance;
  logic               chain_start;
  logic               order_error;
  logic [COUNT_W-1:0] bin_value;
  logic [COUNT_W-1:0] pair_total;
  logic [SUM_W-1:0]   distance_total;

  // Sequence the item: accept, evaluate, memory update, hand off
  ndh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Chain state, bin memory, totals and output register
  ndh_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (s_axis_tuser),
    .in_seq_id      (s_axis_tdata[15:0]),
    .in_locus       (s_axis_tdata[46:16]),
    .in_bin_index   (s_axis_tdata[57:47]),
    .distance       (distance),
    .chain_start    (chain_start),
    .order_error    (order_error),
    .bin_value      (bin_value),
    .pair_total     (pair_total),
    .distance_total (distance_total)
  );

  // Pack the result; the top bit is padding to a whole byte
  assign m_axis_tdata = {1'b0, distance_total, pair_total, bin_value, distance};
  assign m_axis_tuser = {order_error, chain_start};

endmodule
